// File: hw/rtl/aaa_pkg.sv
// Shared types, constants and codes of the analog axis accumulator.
package aaa_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int TS_W          = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int PROD_W        = 2 * DATA_W;

    localparam logic [DATA_W-1:0] ONE_Q       = DATA_W'(1) << FRACTION_BITS;
    localparam logic [DATA_W-1:0] MINUS_ONE_Q = DATA_W'(0) - ONE_Q;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_EMULATION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_MODE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_SPEED  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_SPEED  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_VALUE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMUM_VALUE   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY     = CFG_IDX_W'(6);

    // Binding kinds.
    localparam logic [1:0] KIND_NATIVE  = 2'd0;
    localparam logic [1:0] KIND_BUTTONS = 2'd1;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_ABS_MULTI = 2'd1,
        ERR_NO_EMU    = 2'd2,
        ERR_BAD_KIND  = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SNAP,
        ST_MUL_TS,
        ST_MUL_GAIN,
        ST_MUL_NATIVE,
        ST_APPLY,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MUL_SPEED_TS,
        MUL_STEP_SENS,
        MUL_DELTA_SENS
    } mul_sel_t;

    typedef struct packed {
        logic [1:0]               binding_kind;
        logic                     decrease_pressed;
        logic                     increase_pressed;
        logic [TS_W-1:0]          time_step;
        logic signed [DATA_W-1:0] axis_absolute;
        logic signed [DATA_W-1:0] axis_delta;
        logic                     frame_start;
        logic                     frame_end;
    } in_t;

    typedef struct packed {
        logic                     binding_active;
        logic signed [DATA_W-1:0] axis_value;
        logic signed [DATA_W-1:0] frame_change;
        logic                     frame_idle;
        logic [1:0]               error_code;
        logic                     frame_done;
    } out_t;

    typedef struct packed {
        logic                     allow_emulation;
        logic                     absolute_mode;
        logic [DATA_W-1:0]        decrease_speed;
        logic [DATA_W-1:0]        increase_speed;
        logic signed [DATA_W-1:0] minimum_value;
        logic signed [DATA_W-1:0] maximum_value;
        logic [DATA_W-1:0]        sensitivity;
    } cfg_t;

endpackage

// File: hw/rtl/aaa_mul.sv
// Shared unsigned multiplier with a registered product.
module aaa_mul (
    input  logic                              clk,
    input  logic [aaa_pkg::DATA_W-1:0]        a,
    input  logic [aaa_pkg::DATA_W-1:0]        b,
    output logic [aaa_pkg::PROD_W-1:0]        prod
);

    logic [aaa_pkg::PROD_W-1:0] prod_reg;
    logic [aaa_pkg::PROD_W-1:0] prod_next;

    assign prod_next = aaa_pkg::PROD_W'(a) * aaa_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/aaa_core.sv
// Sequencer and datapath of the axis accumulator around the shared multiplier.
module aaa_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  aaa_pkg::in_t  item,
    input  aaa_pkg::cfg_t cfg,
    output logic          busy,
    output logic          res_valid,
    input  logic          res_take,
    output aaa_pkg::out_t res
);

    localparam int W   = aaa_pkg::DATA_W;
    localparam int FB  = aaa_pkg::FRACTION_BITS;
    localparam int TSW = aaa_pkg::TS_W;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_w(input logic [W:0] v);
        logic [W-1:0] r;
        begin
            if (v[W] != v[W-1])
            begin
                r = v[W] ? SAT_MIN : SAT_MAX;
            end
            else
            begin
                r = v[W-1:0];
            end
            return r;
        end
    endfunction

    aaa_pkg::state_t   state_reg, state_next;
    aaa_pkg::in_t      item_reg;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      delta_reg;
    logic              failed_reg;
    logic [W-1:0]      old_reg;
    logic [W-1:0]      target_reg;
    logic              phase_inc_reg;
    logic              ok_reg;
    aaa_pkg::err_t     err_reg;

    aaa_pkg::mul_sel_t mul_sel;
    logic [W-1:0]      mul_a, mul_b;
    logic [aaa_pkg::PROD_W-1:0] prod;

    logic              is_native, is_buttons, any_button;
    aaa_pkg::err_t     dec_err;
    aaa_pkg::state_t   fin_state;
    logic [W:0]        mid_sum;
    logic [W-1:0]      snap_target;
    logic [W-1:0]      delta_mag;
    logic              step_big, step_neg;
    logic [W-1:0]      step_low, step;
    logic              frame_end;

    assign frame_end  = item_reg.frame_end;
    assign is_native  = item_reg.binding_kind == aaa_pkg::KIND_NATIVE;
    assign is_buttons = item_reg.binding_kind == aaa_pkg::KIND_BUTTONS;
    assign any_button = item_reg.decrease_pressed | item_reg.increase_pressed;
    assign fin_state  = frame_end ? aaa_pkg::ST_CLAMP_HI : aaa_pkg::ST_WRITE;

    // Error classification of the latched binding.
    always_comb
    begin
        if (cfg.absolute_mode && (!item_reg.frame_start || !item_reg.frame_end))
        begin
            dec_err = aaa_pkg::ERR_ABS_MULTI;
        end
        else if (is_buttons && cfg.allow_emulation)
        begin
            dec_err = aaa_pkg::ERR_OK;
        end
        else if (is_buttons)
        begin
            dec_err = aaa_pkg::ERR_NO_EMU;
        end
        else if (!is_native)
        begin
            dec_err = aaa_pkg::ERR_BAD_KIND;
        end
        else
        begin
            dec_err = aaa_pkg::ERR_OK;
        end
    end

    // Snap target in absolute mode; the midpoint rounds toward minus infinity.
    assign mid_sum = {cfg.minimum_value[W-1], cfg.minimum_value}
                   + {cfg.maximum_value[W-1], cfg.maximum_value};

    always_comb
    begin
        if (is_native)
        begin
            snap_target = item_reg.axis_absolute;
        end
        else if (item_reg.decrease_pressed && item_reg.increase_pressed)
        begin
            if (cfg.decrease_speed > cfg.increase_speed)
            begin
                snap_target = cfg.minimum_value;
            end
            else if (cfg.decrease_speed < cfg.increase_speed)
            begin
                snap_target = cfg.maximum_value;
            end
            else
            begin
                snap_target = mid_sum[W:1];
            end
        end
        else if (item_reg.decrease_pressed)
        begin
            snap_target = cfg.minimum_value;
        end
        else
        begin
            snap_target = cfg.maximum_value;
        end
    end

    // Shared multiplier operand selection.
    assign delta_mag = item_reg.axis_delta[W-1] ? (W'(0) - item_reg.axis_delta)
                                                : item_reg.axis_delta;

    always_comb
    begin
        case (mul_sel)
            aaa_pkg::MUL_SPEED_TS:
            begin
                mul_a = phase_inc_reg ? cfg.increase_speed : cfg.decrease_speed;
                mul_b = {{(W-TSW){1'b0}}, item_reg.time_step};
            end
            aaa_pkg::MUL_STEP_SENS:
            begin
                mul_a = prod[W+TSW-1:TSW];
                mul_b = cfg.sensitivity;
            end
            aaa_pkg::MUL_DELTA_SENS:
            begin
                mul_a = delta_mag;
                mul_b = cfg.sensitivity;
            end
            default:
            begin
                mul_a = delta_mag;
                mul_b = cfg.sensitivity;
            end
        endcase
    end

    aaa_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Scaled product to a signed step, saturated to the 32-bit range.
    assign step_big = |prod[aaa_pkg::PROD_W-1:FB+W-1];
    assign step_low = {1'b0, prod[FB+W-2:FB]};
    assign step_neg = is_native ? item_reg.axis_delta[W-1] : !phase_inc_reg;

    always_comb
    begin
        if (step_neg)
        begin
            step = step_big ? SAT_MIN : (W'(0) - step_low);
        end
        else
        begin
            step = step_big ? SAT_MAX : step_low;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aaa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = aaa_pkg::ST_DECODE;
                end
            end
            aaa_pkg::ST_DECODE:
            begin
                if (failed_reg || dec_err != aaa_pkg::ERR_OK)
                begin
                    state_next = aaa_pkg::ST_WRITE;
                end
                else if (cfg.absolute_mode)
                begin
                    state_next = (is_native || any_button) ? aaa_pkg::ST_SNAP : fin_state;
                end
                else if (is_native)
                begin
                    state_next = aaa_pkg::ST_MUL_NATIVE;
                end
                else
                begin
                    state_next = any_button ? aaa_pkg::ST_MUL_TS : fin_state;
                end
            end
            aaa_pkg::ST_SNAP:
            begin
                state_next = fin_state;
            end
            aaa_pkg::ST_MUL_TS:
            begin
                state_next = aaa_pkg::ST_MUL_GAIN;
            end
            aaa_pkg::ST_MUL_GAIN:
            begin
                state_next = aaa_pkg::ST_APPLY;
            end
            aaa_pkg::ST_MUL_NATIVE:
            begin
                state_next = aaa_pkg::ST_APPLY;
            end
            aaa_pkg::ST_APPLY:
            begin
                if (!is_native && !phase_inc_reg && item_reg.increase_pressed)
                begin
                    state_next = aaa_pkg::ST_MUL_TS;
                end
                else
                begin
                    state_next = fin_state;
                end
            end
            aaa_pkg::ST_CLAMP_HI:
            begin
                state_next = aaa_pkg::ST_CLAMP_LO;
            end
            aaa_pkg::ST_CLAMP_LO:
            begin
                state_next = aaa_pkg::ST_WRITE;
            end
            aaa_pkg::ST_WRITE:
            begin
                if (res_take)
                begin
                    state_next = aaa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aaa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy      = state_reg != aaa_pkg::ST_IDLE;
        res_valid = 1'b0;
        mul_sel   = aaa_pkg::MUL_DELTA_SENS;
        case (state_reg)
            aaa_pkg::ST_MUL_TS:   mul_sel   = aaa_pkg::MUL_SPEED_TS;
            aaa_pkg::ST_MUL_GAIN: mul_sel   = aaa_pkg::MUL_STEP_SENS;
            aaa_pkg::ST_WRITE:    res_valid = 1'b1;
            default:              mul_sel   = aaa_pkg::MUL_DELTA_SENS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= aaa_pkg::ST_IDLE;
            acc_reg    <= '0;
            delta_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                aaa_pkg::ST_IDLE:
                begin
                    if (start && item.frame_start)
                    begin
                        delta_reg  <= '0;
                        failed_reg <= 1'b0;
                    end
                end
                aaa_pkg::ST_DECODE:
                begin
                    if (!failed_reg && dec_err != aaa_pkg::ERR_OK)
                    begin
                        failed_reg <= 1'b1;
                    end
                end
                aaa_pkg::ST_SNAP:
                begin
                    delta_reg <= sat_w({target_reg[W-1], target_reg} - {acc_reg[W-1], acc_reg});
                    acc_reg   <= target_reg;
                end
                aaa_pkg::ST_APPLY:
                begin
                    delta_reg <= step;
                    acc_reg   <= sat_w({acc_reg[W-1], acc_reg} + {step[W-1], step});
                end
                aaa_pkg::ST_CLAMP_HI:
                begin
                    if ($signed(acc_reg) > $signed(cfg.maximum_value))
                    begin
                        acc_reg <= cfg.maximum_value;
                    end
                end
                aaa_pkg::ST_CLAMP_LO:
                begin
                    if ($signed(acc_reg) < $signed(cfg.minimum_value))
                    begin
                        acc_reg <= cfg.minimum_value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == aaa_pkg::ST_IDLE && start)
        begin
            item_reg <= item;
        end
        if (state_reg == aaa_pkg::ST_DECODE)
        begin
            old_reg       <= delta_reg;
            target_reg    <= snap_target;
            phase_inc_reg <= !item_reg.decrease_pressed;
            ok_reg        <= !failed_reg && dec_err == aaa_pkg::ERR_OK;
            err_reg       <= failed_reg ? aaa_pkg::ERR_OK : dec_err;
        end
        else if (state_reg == aaa_pkg::ST_APPLY)
        begin
            phase_inc_reg <= 1'b1;
        end
    end

    always_comb
    begin
        res.binding_active = ok_reg && (old_reg != delta_reg);
        res.axis_value     = acc_reg;
        res.frame_change   = delta_reg;
        res.frame_idle     = ok_reg && frame_end && (delta_reg == '0);
        res.error_code     = err_reg;
        res.frame_done     = frame_end;
    end

endmodule

// File: hw/rtl/analog_axis_accumulator.sv
// Analog axis accumulator top level: configuration registers, output register, core.
//
// Usage: each input transaction on in_valid/in_stall/in_data carries one binding of a
// frame; every input transaction yields exactly one output transaction on
// out_valid/out_stall/out_data, in order. Configuration registers are written through
// cfg_write/cfg_index/cfg_data while no transaction is in flight; indexes beyond the
// register list are ignored.
// Sequencing: the core accepts no further binding until it has handed the current result
// to the output register. A rejected binding goes from decode straight to the write step;
// a snap in absolute mode takes the snap step, a native delta one multiplier pass and an
// apply step, each emulated button two passes and an apply step, and the two clamp steps
// are added at frame end. All passes use the single shared 32x32 multiplier. The result
// is loaded into the output register as the core leaves the write step.
// Reset clears the axis value, the frame delta and the frame failure flag, and loads
// the configuration defaults (emulation allowed, relative mode, speeds and sensitivity
// 1.0, limits -1.0 and 1.0). While out_stall is high the result is held; one more
// input transaction may still be accepted and is held in the core until the output
// register frees.
module analog_axis_accumulator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  aaa_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output aaa_pkg::out_t                      out_data,
    input  logic                               cfg_write,
    input  logic [aaa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aaa_pkg::DATA_W-1:0]         cfg_data
);

    aaa_pkg::cfg_t cfg_reg;
    logic          out_valid_reg, out_valid_next;
    aaa_pkg::out_t out_data_reg;
    logic          core_busy;
    logic          res_valid, res_take;
    aaa_pkg::out_t res;
    logic          start;

    assign start    = in_valid && !core_busy;
    assign in_stall = core_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.allow_emulation <= 1'b1;
            cfg_reg.absolute_mode   <= 1'b0;
            cfg_reg.decrease_speed  <= aaa_pkg::ONE_Q;
            cfg_reg.increase_speed  <= aaa_pkg::ONE_Q;
            cfg_reg.minimum_value   <= aaa_pkg::MINUS_ONE_Q;
            cfg_reg.maximum_value   <= aaa_pkg::ONE_Q;
            cfg_reg.sensitivity     <= aaa_pkg::ONE_Q;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aaa_pkg::CFG_ALLOW_EMULATION: cfg_reg.allow_emulation <= cfg_data[0];
                aaa_pkg::CFG_ABSOLUTE_MODE:   cfg_reg.absolute_mode   <= cfg_data[0];
                aaa_pkg::CFG_DECREASE_SPEED:  cfg_reg.decrease_speed  <= cfg_data;
                aaa_pkg::CFG_INCREASE_SPEED:  cfg_reg.increase_speed  <= cfg_data;
                aaa_pkg::CFG_MINIMUM_VALUE:   cfg_reg.minimum_value   <= cfg_data;
                aaa_pkg::CFG_MAXIMUM_VALUE:   cfg_reg.maximum_value   <= cfg_data;
                aaa_pkg::CFG_SENSITIVITY:     cfg_reg.sensitivity     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    aaa_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (in_data),
        .cfg       (cfg_reg),
        .busy      (core_busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // The output register is reloaded once the previous result has been taken.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An accepted binding keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // A rejected binding neither moves the frame nor reports it idle.
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code != aaa_pkg::ERR_OK)
            |-> (!out_data.binding_active && !out_data.frame_idle))
        else $error("error result reports activity");

    // An idle frame is only reported on the frame's last binding with a zero delta.
    a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_idle)
            |-> (out_data.frame_done && out_data.frame_change == '0))
        else $error("idle reported without frame end or with nonzero delta");

endmodule
